[rtl/rbc_pkg.sv]
`timescale 1ns / 1ps
// rbc_pkg: shared types, size decode, S-box tables and round helper functions
// for the Rijndael block cipher. No dependencies; used by every file but rbc_if.
package rbc_pkg;

  // Key store geometry: one row of up to eight columns per round key
  localparam int NUM_COLS = 8;
  localparam int KEY_ROWS = 15;

  localparam logic [7:0] RCON_INIT = 8'h01;
  localparam logic [7:0] GF_POLY   = 8'h1B;

  // Configuration register indexes
  localparam logic [2:0] CFG_KEY_0   = 3'd0;
  localparam logic [2:0] CFG_KEY_1   = 3'd1;
  localparam logic [2:0] CFG_KEY_2   = 3'd2;
  localparam logic [2:0] CFG_KEY_3   = 3'd3;
  localparam logic [2:0] CFG_KEY_LEN = 3'd4;
  localparam logic [2:0] CFG_BLK_LEN = 3'd5;
  localparam logic [2:0] CFG_DECRYPT = 3'd6;

  typedef logic [255:0] blk_t;
  typedef logic [1:0]   size_code_t;

  // Controls of the round unit
  typedef struct packed {
    logic       first;
    logic       last;
    logic       decrypt;
    logic [3:0] nb;
  } rnd_ctl_t;

  // Controls of the key expansion
  typedef struct packed {
    logic       start;
    logic [3:0] nb;
    logic [3:0] nk;
  } ks_ctl_t;

  // Size code to words; code 3 acts as 256 bits
  function automatic logic [3:0] code_words(size_code_t c);
    case (c)
      2'd0:    return 4'd4;
      2'd1:    return 4'd6;
      default: return 4'd8;
    endcase
  endfunction

  function automatic logic [3:0] num_rounds(logic [3:0] nb, logic [3:0] nk);
    return ((nb > nk) ? nb : nk) + 4'd6;
  endfunction

  function automatic logic [7:0] xtime(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
  endfunction

  // Multiply by a small constant (up to 15)
  function automatic logic [7:0] gmul_c(logic [7:0] a, logic [3:0] b);
    logic [7:0] a2, a4, a8;
    a2 = xtime(a);
    a4 = xtime(a2);
    a8 = xtime(a4);
    return (b[0] ? a : 8'h00) ^ (b[1] ? a2 : 8'h00) ^
           (b[2] ? a4 : 8'h00) ^ (b[3] ? a8 : 8'h00);
  endfunction

  // Full field multiply, elaboration use only
  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc, x;
    acc = 8'h00;
    x = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc = acc ^ x;
      x = xtime(x);
    end
    return acc;
  endfunction

  // S-box: inverse in GF(2^8) then the affine map
  function automatic logic [2047:0] gen_sbox();
    logic [2047:0] flat;
    logic [7:0] inv, base, s;
    int e;
    flat = '0;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h01;
      base = 8'(x);
      for (e = 254; e > 0; e = e >> 1) begin
        if (e[0]) inv = gf_mul(inv, base);
        base = gf_mul(base, base);
      end
      if (x == 0) inv = 8'h00;
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^
          {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      flat[x*8 +: 8] = s;
    end
    return flat;
  endfunction

  function automatic logic [2047:0] gen_inv_sbox(logic [2047:0] fwd);
    logic [2047:0] flat;
    logic [7:0] s;
    flat = '0;
    for (int x = 0; x < 256; x++) begin
      s = fwd[x*8 +: 8];
      flat[int'(s)*8 +: 8] = 8'(x);
    end
    return flat;
  endfunction

  localparam logic [2047:0] SBOX_FLAT     = gen_sbox();
  localparam logic [2047:0] INV_SBOX_FLAT = gen_inv_sbox(SBOX_FLAT);

  function automatic logic [7:0] sub_byte(logic [7:0] b);
    return SBOX_FLAT[{b, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] inv_sub_byte(logic [7:0] b);
    return INV_SBOX_FLAT[{b, 3'b000} +: 8];
  endfunction

  function automatic logic [31:0] sub_word(logic [31:0] w);
    return {sub_byte(w[31:24]), sub_byte(w[23:16]), sub_byte(w[15:8]), sub_byte(w[7:0])};
  endfunction

  // Row rotation over nb columns; columns past nb come out zero
  function automatic blk_t row_rotate(blk_t st, logic [3:0] nb, logic inv);
    blk_t o;
    logic [3:0] sh, idx;
    o = '0;
    for (int c = 0; c < NUM_COLS; c++) begin
      if (c < int'(nb)) begin
        o[255 - 32*c -: 8] = st[255 - 32*c -: 8];
        for (int r = 1; r < 4; r++) begin
          if (nb == 4'd8 && r > 1) sh = 4'(r + 1);
          else sh = 4'(r);
          if (inv) idx = 4'(c) + nb - sh;
          else idx = 4'(c) + sh;
          if (idx >= nb) idx = idx - nb;
          o[255 - 32*c - 8*r -: 8] = st[255 - 32*int'(idx) - 8*r -: 8];
        end
      end
    end
    return o;
  endfunction

  // One column of the mix step; row 0 in the top byte
  function automatic logic [31:0] mix_column(logic [31:0] col, logic inv);
    logic [7:0] a [4];
    logic [3:0] m [4];
    logic [7:0] v;
    logic [31:0] o;
    a[0] = col[31:24];
    a[1] = col[23:16];
    a[2] = col[15:8];
    a[3] = col[7:0];
    if (inv) begin
      m[0] = 4'd14; m[1] = 4'd11; m[2] = 4'd13; m[3] = 4'd9;
    end else begin
      m[0] = 4'd2;  m[1] = 4'd3;  m[2] = 4'd1;  m[3] = 4'd1;
    end
    o = '0;
    for (int r = 0; r < 4; r++) begin
      v = 8'h00;
      for (int k = 0; k < 4; k++) v = v ^ gmul_c(a[k], m[(k + 4 - r) & 3]);
      o[31 - 8*r -: 8] = v;
    end
    return o;
  endfunction

endpackage

[rtl/rbc_if.sv]
`timescale 1ns / 1ps
// rbc_if: valid/ready channels for input and result blocks.
// Depends on nothing; used by the top level.
interface rbc_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_in_0;
  logic [63:0] block_in_1;
  logic [63:0] block_in_2;
  logic [63:0] block_in_3;
  modport source (output valid, block_in_0, block_in_1, block_in_2, block_in_3,
                  input ready);
  modport sink (input valid, block_in_0, block_in_1, block_in_2, block_in_3,
                output ready);
endinterface

interface rbc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_out_0;
  logic [63:0] block_out_1;
  logic [63:0] block_out_2;
  logic [63:0] block_out_3;
  modport source (output valid, block_out_0, block_out_1, block_out_2, block_out_3,
                  input ready);
  modport sink (input valid, block_out_0, block_out_1, block_out_2, block_out_3,
                output ready);
endinterface

[rtl/rijndael_block_cipher.sv]
`timescale 1ns / 1ps
// rijndael_block_cipher: top level; config registers, round sequencer and
// result register. Uses rbc_pkg, rbc_if, rbc_key_sched and rbc_round.
//
//   port       dir   handshake        payload
//   blk_in     sink  valid / ready    block_in_0..3  (64 b each)
//   blk_out    src   valid / ready    block_out_0..3 (64 b each)
//   cfg        in    cfg_write_en     cfg_index (3 b), cfg_data (64 b)
//
// A block runs one round per cycle through the shared round unit, with one key
// row read from the store per round. After reset or any write to config
// indexes 0 to 6, the first block first waits for key expansion, one word a
// cycle. Reset is synchronous; a finished block waits in the result register
// while the next request is taken, and the sequencer holds if it is still
// full.
module rijndael_block_cipher (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  rbc_in_if.sink      blk_in,
  rbc_out_if.source   blk_out
);

  typedef enum logic [1:0] {S_IDLE, S_EXPAND, S_RUN, S_DONE} state_t;

  state_t             state;
  logic [63:0]        key_word [4];
  logic [1:0]         key_len;
  logic [1:0]         blk_len;
  logic               decrypt;
  logic               stale;
  rbc_pkg::blk_t      st_vec;
  logic [3:0]         step;
  logic               out_valid;
  logic [63:0]        out_word [4];

  logic [3:0]         nb, nk, rounds, next_k, rd_row;
  logic               in_accept, ks_done;
  rbc_pkg::ks_ctl_t   ks_ctl;
  rbc_pkg::rnd_ctl_t  rnd_ctl;
  rbc_pkg::blk_t      round_key, round_out;

  assign nb        = rbc_pkg::code_words(blk_len);
  assign nk        = rbc_pkg::code_words(key_len);
  assign rounds    = rbc_pkg::num_rounds(nb, nk);
  assign in_accept = blk_in.valid && blk_in.ready;
  assign blk_in.ready = (state == S_IDLE);

  // key row request for the next step; step 0 outside a run and once the last round is done
  assign next_k = (state == S_RUN && step != rounds) ? step + 4'd1 : 4'd0;
  assign rd_row = decrypt ? rounds - next_k : next_k;

  assign ks_ctl.start = in_accept && stale;
  assign ks_ctl.nb    = nb;
  assign ks_ctl.nk    = nk;

  assign rnd_ctl.first   = (step == 4'd0);
  assign rnd_ctl.last    = (step == rounds);
  assign rnd_ctl.decrypt = decrypt;
  assign rnd_ctl.nb      = nb;

  rbc_key_sched u_key_sched (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ks_ctl),
    .key_vec ({key_word[0], key_word[1], key_word[2], key_word[3]}),
    .rd_row  (rd_row),
    .done    (ks_done),
    .rd_data (round_key)
  );

  rbc_round u_round (
    .state_in  (st_vec),
    .round_key (round_key),
    .ctl       (rnd_ctl),
    .state_out (round_out)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < 4; j++) key_word[j] <= '0;
      key_len <= '0;
      blk_len <= '0;
      decrypt <= 1'b0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        rbc_pkg::CFG_KEY_0:   key_word[0] <= cfg_data;
        rbc_pkg::CFG_KEY_1:   key_word[1] <= cfg_data;
        rbc_pkg::CFG_KEY_2:   key_word[2] <= cfg_data;
        rbc_pkg::CFG_KEY_3:   key_word[3] <= cfg_data;
        rbc_pkg::CFG_KEY_LEN: key_len <= cfg_data[1:0];
        rbc_pkg::CFG_BLK_LEN: blk_len <= cfg_data[1:0];
        rbc_pkg::CFG_DECRYPT: decrypt <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      stale     <= 1'b1;
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            st_vec <= {blk_in.block_in_0, blk_in.block_in_1,
                       blk_in.block_in_2, blk_in.block_in_3};
            step   <= '0;
            state  <= stale ? S_EXPAND : S_RUN;
          end
        end
        S_EXPAND: begin
          if (ks_done) state <= S_RUN;
        end
        S_RUN: begin
          st_vec <= round_out;
          step   <= step + 4'd1;
          if (step == rounds) state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || blk_out.ready) begin
            out_word[0] <= st_vec[255:192];
            out_word[1] <= st_vec[191:128];
            out_word[2] <= (nb == 4'd4) ? 64'h0 : st_vec[127:64];
            out_word[3] <= (nb == 4'd8) ? st_vec[63:0] : 64'h0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      // result register fills from the done state, empties on a taken result
      if (state == S_DONE && (!out_valid || blk_out.ready)) out_valid <= 1'b1;
      else if (out_valid && blk_out.ready) out_valid <= 1'b0;
      // schedule goes stale on any register write, fresh once expanded
      if (cfg_write_en && cfg_index <= rbc_pkg::CFG_DECRYPT) stale <= 1'b1;
      else if (state == S_EXPAND && ks_done) stale <= 1'b0;
    end
  end

  assign blk_out.valid       = out_valid;
  assign blk_out.block_out_0 = out_word[0];
  assign blk_out.block_out_1 = out_word[1];
  assign blk_out.block_out_2 = out_word[2];
  assign blk_out.block_out_3 = out_word[3];

  // rounds never run on a stale schedule
  a_run_fresh: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> !stale) else $error("round run with stale key schedule");

  // step counter stays within the round count
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> (step <= rounds)) else $error("round step overran");

  // expansion completes only while waiting for it
  a_done_expand: assert property (@(posedge clk) disable iff (rst)
    ks_done |-> (state == S_EXPAND)) else $error("unexpected expansion done");

  // a taken request blocks the input next cycle
  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> !blk_in.ready) else $error("input ready while busy");

endmodule

[rtl/rbc_key_sched.sv]
`timescale 1ns / 1ps
// rbc_key_sched: expands the key one word per cycle into the round key store
// (15 rows of 8 columns) and serves one registered row per cycle. Uses rbc_pkg.
module rbc_key_sched (
  input  logic                clk,
  input  logic                rst,
  input  rbc_pkg::ks_ctl_t    ctl,
  input  logic [255:0]        key_vec,
  input  logic [3:0]          rd_row,
  output logic                done,
  output rbc_pkg::blk_t       rd_data
);

  typedef enum logic {KS_IDLE, KS_RUN} ks_state_t;

  ks_state_t   state;
  logic [6:0]  word_idx;
  logic [2:0]  kc;
  logic [2:0]  col;
  logic [3:0]  row;
  logic [7:0]  rcon;
  logic [31:0] win [8];
  logic [31:0] new_word;
  logic [31:0] t;
  logic [31:0] old_word;
  logic [3:0]  rounds;
  logic [6:0]  total;
  logic        from_key;
  logic [7:0][31:0] key_mem [rbc_pkg::KEY_ROWS];

  assign rounds   = rbc_pkg::num_rounds(ctl.nb, ctl.nk);
  assign total    = {3'b000, ctl.nb} * {3'b000, rounds + 4'd1};
  assign from_key = word_idx < {3'b000, ctl.nk};

  // word i-nk from the window of recent words
  always_comb begin
    case (ctl.nk)
      4'd4:    old_word = win[3];
      4'd6:    old_word = win[5];
      default: old_word = win[7];
    endcase
  end

  // next schedule word
  always_comb begin
    t = win[0];
    if (kc == 3'd0) begin
      t = rbc_pkg::sub_word({win[0][23:0], win[0][31:24]}) ^ {rcon, 24'h000000};
    end else if (ctl.nk == 4'd8 && kc == 3'd4) begin
      t = rbc_pkg::sub_word(win[0]);
    end
    if (from_key) new_word = key_vec[255 - 32*int'(word_idx[2:0]) -: 32];
    else new_word = old_word ^ t;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= KS_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        KS_IDLE: begin
          if (ctl.start) begin
            state    <= KS_RUN;
            word_idx <= '0;
            kc       <= '0;
            col      <= '0;
            row      <= '0;
            rcon     <= rbc_pkg::RCON_INIT;
          end
        end
        KS_RUN: begin
          word_idx <= word_idx + 7'd1;
          kc  <= ({1'b0, kc} == ctl.nk - 4'd1) ? 3'd0 : kc + 3'd1;
          if ({1'b0, col} == ctl.nb - 4'd1) begin
            col <= '0;
            row <= row + 4'd1;
          end else begin
            col <= col + 3'd1;
          end
          if (!from_key && kc == 3'd0) rcon <= rbc_pkg::xtime(rcon);
          if (word_idx == total - 7'd1) begin
            state <= KS_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= KS_IDLE;
      endcase
    end
  end

  // window of the last eight words
  always_ff @(posedge clk) begin
    if (state == KS_RUN) begin
      win[0] <= new_word;
      for (int j = 1; j < 8; j++) win[j] <= win[j-1];
    end
  end

  // round key store
  always_ff @(posedge clk) begin
    if (state == KS_RUN) key_mem[row][~col] <= new_word;
    rd_data <= key_mem[rd_row];
  end

endmodule

[rtl/rbc_round.sv]
`timescale 1ns / 1ps
// rbc_round: one full cipher or inverse-cipher round over the whole state,
// reused for every round. Uses rbc_pkg.
module rbc_round (
  input  rbc_pkg::blk_t    state_in,
  input  rbc_pkg::blk_t    round_key,
  input  rbc_pkg::rnd_ctl_t ctl,
  output rbc_pkg::blk_t    state_out
);

  rbc_pkg::blk_t subbed, shifted, mixed, enc_res, dec_pre, dec_res;

  // forward path: sub, shift, mix unless final round
  always_comb begin
    for (int i = 0; i < 32; i++) subbed[8*i +: 8] = rbc_pkg::sub_byte(state_in[8*i +: 8]);
    shifted = rbc_pkg::row_rotate(subbed, ctl.nb, 1'b0);
    for (int c = 0; c < 8; c++) mixed[32*c +: 32] = rbc_pkg::mix_column(shifted[32*c +: 32], 1'b0);
    enc_res = ctl.last ? shifted : mixed;
  end

  // inverse path: unshift, unsub, add key, unmix unless final round
  always_comb begin
    rbc_pkg::blk_t us;
    us = rbc_pkg::row_rotate(state_in, ctl.nb, 1'b1);
    for (int i = 0; i < 32; i++) dec_pre[8*i +: 8] = rbc_pkg::inv_sub_byte(us[8*i +: 8]) ^
                                                    round_key[8*i +: 8];
    for (int c = 0; c < 8; c++) dec_res[32*c +: 32] = rbc_pkg::mix_column(dec_pre[32*c +: 32], 1'b1);
  end

  // first step is the plain key addition
  always_comb begin
    if (ctl.first) state_out = state_in ^ round_key;
    else if (!ctl.decrypt) state_out = enc_res ^ round_key;
    else if (ctl.last) state_out = dec_pre;
    else state_out = dec_res;
  end

endmodule

[sim/rijndael_block_cipher_tb.sv]
`timescale 1ns / 1ps
// rijndael_block_cipher_tb: self-checking bench for the Rijndael block cipher.
// Depends on rbc_pkg, rbc_if and the rijndael_block_cipher top level.
module rijndael_block_cipher_tb;

  typedef struct packed {
    logic [63:0] w0;
    logic [63:0] w1;
    logic [63:0] w2;
    logic [63:0] w3;
  } quad_t;

  // index past the register list
  localparam logic [2:0] CFG_UNUSED = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic [2:0]  cfg_index = rbc_pkg::CFG_KEY_0;
  logic [63:0] cfg_data = '0;

  rbc_in_if  blk_in ();
  rbc_out_if blk_out ();

  rijndael_block_cipher u_top (
    .clk(clk), .rst(rst), .cfg_write_en(cfg_write_en), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .blk_in(blk_in.sink), .blk_out(blk_out.source)
  );

  always #1 clk = ~clk;

  // Predictor state: S-boxes, key, sizes, direction, expanded schedule
  logic [7:0]  fbox [256];
  logic [7:0]  ibox [256];
  logic [63:0] key_q [4];
  logic [1:0]  klen_q, blen_q;
  logic        dec_q;
  logic [31:0] sched [120];

  quad_t cipher_q [$];
  int    errors = 0;
  int    n_sent = 0;
  int    n_seen = 0;
  int    idle_cnt = 0;
  bit    no_idle = 1'b0;
  bit    hold_sink = 1'b0;
  bit    done_flag = 1'b0;

  function automatic logic [7:0] ff_dbl(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] ff_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    while (b != 0) begin
      if (b[0]) acc ^= a;
      a = ff_dbl(a);
      b = b >> 1;
    end
    return acc;
  endfunction

  task automatic build_boxes();
    logic [7:0] inv, base, s;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h01;
      base = 8'(x);
      for (int e = 254; e > 0; e = e >> 1) begin
        if (e[0]) inv = ff_mul(inv, base);
        base = ff_mul(base, base);
      end
      if (x == 0) inv = 8'h00;
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      fbox[x] = s;
      ibox[s] = 8'(x);
    end
  endtask

  function automatic int size_words(logic [1:0] c);
    return (c == 2'd0) ? 4 : (c == 2'd1) ? 6 : 8;
  endfunction

  function automatic logic [31:0] box_word(logic [31:0] w);
    return {fbox[w[31:24]], fbox[w[23:16]], fbox[w[15:8]], fbox[w[7:0]]};
  endfunction

  // Key schedule for the current configuration
  task automatic build_schedule();
    int nb, nk, nr;
    logic [7:0]  rc;
    logic [31:0] t;
    nb = size_words(blen_q);
    nk = size_words(klen_q);
    nr = ((nb > nk) ? nb : nk) + 6;
    rc = 8'h01;
    for (int i = 0; i < nk; i++)
      sched[i] = i[0] ? key_q[i >> 1][31:0] : key_q[i >> 1][63:32];
    for (int i = nk; i < nb * (nr + 1); i++) begin
      t = sched[i - 1];
      if (i % nk == 0) begin
        t = box_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = ff_dbl(rc);
      end else if (nk > 6 && i % nk == 4) begin
        t = box_word(t);
      end
      sched[i] = sched[i - nk] ^ t;
    end
  endtask

  // Full encrypt or decrypt of one block under the current settings
  function automatic quad_t cipher_block(quad_t d);
    logic [7:0] s [32];
    logic [7:0] t [32];
    logic [7:0] a [4];
    logic [7:0] mf [4];
    logic [7:0] mi [4];
    logic [255:0] flat;
    int nb, nk, nr, sh [3], from, r;
    quad_t o;
    mf = '{8'd2, 8'd3, 8'd1, 8'd1};
    mi = '{8'd14, 8'd11, 8'd13, 8'd9};
    nb = size_words(blen_q);
    nk = size_words(klen_q);
    nr = ((nb > nk) ? nb : nk) + 6;
    if (nb == 8) sh = '{1, 3, 4};
    else sh = '{1, 2, 3};
    flat = d;
    for (int i = 0; i < 32; i++) s[i] = (i < 4 * nb) ? flat[255 - 8*i -: 8] : 8'h00;
    r = dec_q ? nr : 0;
    for (int step = 0; step <= nr; step++) begin
      if (step > 0) begin
        if (dec_q) r--; else r++;
        // rows, then bytes (the two commute)
        t = s;
        for (int rr = 1; rr < 4; rr++)
          for (int c = 0; c < nb; c++) begin
            from = dec_q ? (c + nb - sh[rr-1]) % nb : (c + sh[rr-1]) % nb;
            s[4*c + rr] = t[4*from + rr];
          end
        for (int i = 0; i < 4 * nb; i++) s[i] = dec_q ? ibox[s[i]] : fbox[s[i]];
        if (!dec_q && r != nr) begin
          for (int c = 0; c < nb; c++) begin
            for (int k = 0; k < 4; k++) a[k] = s[4*c + k];
            for (int rr = 0; rr < 4; rr++) begin
              s[4*c + rr] = 8'h00;
              for (int k = 0; k < 4; k++) s[4*c + rr] ^= ff_mul(a[k], mf[(k + 4 - rr) & 3]);
            end
          end
        end
      end
      for (int c = 0; c < nb; c++)
        for (int rr = 0; rr < 4; rr++) s[4*c + rr] ^= sched[r*nb + c][31 - 8*rr -: 8];
      if (dec_q && step > 0 && r != 0) begin
        for (int c = 0; c < nb; c++) begin
          for (int k = 0; k < 4; k++) a[k] = s[4*c + k];
          for (int rr = 0; rr < 4; rr++) begin
            s[4*c + rr] = 8'h00;
            for (int k = 0; k < 4; k++) s[4*c + rr] ^= ff_mul(a[k], mi[(k + 4 - rr) & 3]);
          end
        end
      end
    end
    flat = '0;
    for (int i = 0; i < 4 * nb; i++) flat[255 - 8*i -: 8] = s[i];
    o = flat;
    return o;
  endfunction

  // Register write; only called with nothing in flight
  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    case (idx)
      rbc_pkg::CFG_KEY_0, rbc_pkg::CFG_KEY_1, rbc_pkg::CFG_KEY_2,
      rbc_pkg::CFG_KEY_3: key_q[idx] = val;
      rbc_pkg::CFG_KEY_LEN: klen_q = val[1:0];
      rbc_pkg::CFG_BLK_LEN: blen_q = val[1:0];
      rbc_pkg::CFG_DECRYPT: dec_q = val[0];
      default: ;
    endcase
    build_schedule();
  endtask

  // Drop valid and wait until every expected result is back
  task automatic drain();
    blk_in.valid <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic setup(logic [1:0] kl, logic [1:0] bl, logic dm, bit rand_key);
    drain();
    for (int i = 0; i < 4; i++)
      write_reg(3'(i), rand_key ? {$urandom, $urandom} : {8{8'(i * 8 + 1)}});
    write_reg(rbc_pkg::CFG_KEY_LEN, {62'd0, kl});
    write_reg(rbc_pkg::CFG_BLK_LEN, {62'd0, bl});
    write_reg(rbc_pkg::CFG_DECRYPT, {63'd0, dm});
  endtask

  // Send one request, holding valid until taken; valid is dropped by the
  // next idle gap or by drain
  task automatic send_block(quad_t d);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      blk_in.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    blk_in.valid <= 1'b1;
    {blk_in.block_in_0, blk_in.block_in_1, blk_in.block_in_2, blk_in.block_in_3} <= d;
    @(posedge clk);
    while (!blk_in.ready) @(posedge clk);
    cipher_q.push_back(cipher_block(d));
    n_sent++;
  endtask

  function automatic quad_t rand_quad();
    quad_t d;
    d = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(0, 7))
      0: d = '0;
      1: d = '1;
      2: d = {$urandom, $urandom, 192'd0};
      default: ;
    endcase
    return d;
  endfunction

  // Result checker
  always @(posedge clk) begin
    quad_t got, want;
    if (!rst && blk_out.valid && blk_out.ready) begin
      got = {blk_out.block_out_0, blk_out.block_out_1, blk_out.block_out_2,
             blk_out.block_out_3};
      if (cipher_q.size() == 0) begin
        $display("%0t: unexpected block %h", $time, got);
        errors++;
      end else begin
        want = cipher_q.pop_front();
        if (got.w0 !== want.w0) begin
          $display("%0t: block_out_0 exp %h got %h", $time, want.w0, got.w0); errors++;
        end
        if (got.w1 !== want.w1) begin
          $display("%0t: block_out_1 exp %h got %h", $time, want.w1, got.w1); errors++;
        end
        if (got.w2 !== want.w2) begin
          $display("%0t: block_out_2 exp %h got %h", $time, want.w2, got.w2); errors++;
        end
        if (got.w3 !== want.w3) begin
          $display("%0t: block_out_3 exp %h got %h", $time, want.w3, got.w3); errors++;
        end
      end
      n_seen++;
    end
  end

  // Result-side stalls in bursts
  always @(posedge clk) begin
    if (rst || no_idle) begin
      blk_out.ready <= 1'b1;
    end else if (hold_sink) begin
      blk_out.ready <= 1'b0;
    end else if (idle_cnt > 0) begin
      idle_cnt <= idle_cnt - 1;
      blk_out.ready <= (idle_cnt == 1);
    end else if ($urandom_range(0, 7) == 0) begin
      idle_cnt <= $urandom_range(1, 13);
      blk_out.ready <= 1'b0;
    end else begin
      blk_out.ready <= 1'b1;
    end
  end

  // Watchdog on cycles with no accepted request, taken result or config write
  always @(posedge clk) begin
    int quiet;
    if ((blk_in.valid && blk_in.ready) || (blk_out.valid && blk_out.ready) || cfg_write_en)
      quiet = 0;
    else
      quiet++;
    if (quiet > 5000 && !done_flag) begin
      $display("rijndael_block_cipher verification failed");
      $finish;
    end
  end

  task automatic test_directed();
    quad_t pats [5];
    pats = '{'0, '1, {8{32'h00112233}}, {4{64'h0123456789abcdef}},
             {64'h8000000000000000, 192'd1}};
    for (int kl = 0; kl < 4; kl++)
      for (int bl = 0; bl < 4; bl++)
        if (kl == 3 || bl == 3 || (kl + bl) % 2 == 0) begin
          setup(2'(kl), 2'(bl), 1'b0, 1'b0);
          send_block(pats[(kl + bl) % 5]);
          drain();
          write_reg(rbc_pkg::CFG_DECRYPT, 64'd1);
          send_block(pats[(kl * 3 + bl) % 5]);
        end
    // unused index is ignored and leaves the schedule alone
    drain();
    write_reg(CFG_UNUSED, '1);
    send_block('1);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0)
        setup(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), 1'($urandom), 1'b1);
      send_block(rand_quad());
    end
  endtask

  // Sink holds off long while requests pile up, then the sender waits out
  task automatic test_backpressure();
    fork
      begin
        hold_sink = 1'b1;
        repeat (300) @(posedge clk);
        hold_sink = 1'b0;
      end
      for (int i = 0; i < 10; i++) send_block(rand_quad());
    join
    drain();
  endtask

  initial begin
    blk_in.valid = 1'b0;
    {blk_in.block_in_0, blk_in.block_in_1, blk_in.block_in_2, blk_in.block_in_3} = '0;
    blk_out.ready = 1'b1;
    build_boxes();
    key_q = '{default: '0};
    klen_q = 2'd0;
    blen_q = 2'd0;
    dec_q = 1'b0;
    build_schedule();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_random(780);
    no_idle = 1'b1;
    test_random(90);
    drain();
    repeat (30) @(posedge clk);
    done_flag = 1'b1;
    $display("Covered %0d blocks, %0d results, all key/block sizes, both directions.",
             n_sent, n_seen);
    if (errors == 0 && cipher_q.size() == 0)
      $display("rijndael_block_cipher verification clean");
    else
      $display("rijndael_block_cipher verification failed");
    $finish;
  end

endmodule
